### src/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants for the compare timer bank.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int NUM_TIMERS = 5;
  localparam int DATA_W     = 32;
  localparam int CYC_W      = 16;
  localparam int IDX_W      = 3;
  localparam int IRQ_W      = 5;
  localparam int LAST_SHIFT = 12;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_CTRL   = 2'd2;
  localparam logic [1:0] REG_STATUS = 2'd3;

  localparam int CTRL_CLR_BIT     = 0;
  localparam int CTRL_RESTART_BIT = 1;
  localparam int CTRL_ENABLE_BIT  = 2;
  localparam int STATUS_BIT       = 0;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        reg_select;
    logic [IDX_W-1:0]  timer_index;
    logic [DATA_W-1:0] write_data;
    logic [CYC_W-1:0]  tick_cycles;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_mask;
  } out_item_t;

endpackage

### src/ctb_bank.sv
// ----------------------------------------------------------------------------
// ctb_bank
// Timer state and per-timer tick, read and write logic.
// ----------------------------------------------------------------------------
module ctb_bank
  import ctb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  logic [DATA_W-1:0]     cnt_r   [NUM_TIMERS];
  logic [DATA_W-1:0]     cnt_nxt [NUM_TIMERS];
  logic [DATA_W-1:0]     tgt_r   [NUM_TIMERS];
  logic [DATA_W-1:0]     tgt_nxt [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] en_r, en_nxt;
  logic [NUM_TIMERS-1:0] rst_bit_r, rst_bit_nxt;
  logic [NUM_TIMERS-1:0] stat_r, stat_nxt;
  logic [NUM_TIMERS-1:0] match;
  logic [DATA_W-1:0]     rd;
  logic [DATA_W-1:0]     sum;
  logic                  is_last;
  logic                  hit;

  always_comb begin
    rd          = '0;
    match       = '0;
    en_nxt      = en_r;
    rst_bit_nxt = rst_bit_r;
    stat_nxt    = stat_r;
    sum         = '0;
    is_last     = 1'b0;
    hit         = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      tgt_nxt[i] = tgt_r[i];
    end
    for (int i = 0; i < NUM_TIMERS; i++) begin
      is_last = (i == NUM_TIMERS - 1);
      hit     = ({1'b0, item.timer_index} == (IDX_W + 1)'(i));
      sum     = cnt_r[i] + DATA_W'(item.tick_cycles);
      case (item.kind)
        KIND_TICK: begin
          if (en_r[i]) begin
            cnt_nxt[i] = sum;
            if (sum >= tgt_r[i]) begin
              stat_nxt[i] = 1'b1;
              match[i]    = 1'b1;
            end
          end
        end
        KIND_READ: begin
          if (hit) begin
            case (item.reg_select)
              REG_TARGET: rd = is_last ? (tgt_r[i] << LAST_SHIFT) : tgt_r[i];
              REG_COUNT:  rd = is_last ? (cnt_r[i] << LAST_SHIFT) : cnt_r[i];
              REG_CTRL: begin
                rd[CTRL_RESTART_BIT] = rst_bit_r[i];
                rd[CTRL_ENABLE_BIT]  = en_r[i];
              end
              default: rd[STATUS_BIT] = stat_r[i];
            endcase
          end
        end
        KIND_WRITE: begin
          if (hit) begin
            case (item.reg_select)
              REG_TARGET: tgt_nxt[i] = is_last ? (item.write_data >> LAST_SHIFT)
                                                : item.write_data;
              REG_CTRL: begin
                if (item.write_data[CTRL_CLR_BIT]) cnt_nxt[i] = '0;
                rst_bit_nxt[i] = item.write_data[CTRL_RESTART_BIT];
                en_nxt[i]      = item.write_data[CTRL_ENABLE_BIT];
              end
              REG_STATUS: stat_nxt[i] = stat_r[i] & item.write_data[STATUS_BIT];
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign result.read_data = rd;
  assign result.irq_mask  = IRQ_W'({{IRQ_W{1'b0}}, match});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= '0;
      rst_bit_r <= '0;
      stat_r    <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        cnt_r[i] <= '0;
        tgt_r[i] <= '0;
      end
    end else if (fire) begin
      en_r      <= en_nxt;
      rst_bit_r <= rst_bit_nxt;
      stat_r    <= stat_nxt;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
        tgt_r[i] <= tgt_nxt[i];
      end
    end
  end

endmodule

### src/ctb_out_reg.sv
// ----------------------------------------------------------------------------
// ctb_out_reg
// Result register holding one result until the sink takes it.
// ----------------------------------------------------------------------------
module ctb_out_reg
  import ctb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

### src/compare_timer_bank_with_irq.sv
// Takes one request per clock while in_stall is low. A request waits in the input
// register until it fires, when the timer bank applies it to every timer in
// parallel, and its result sits in the result register from the next cycle,
// so each request gives exactly one result. While the result register is
// held by out_stall, one further request is still taken into the input
// register.
// ----------------------------------------------------------------------------
// compare_timer_bank_with_irq
// Bank of compare timers with interrupt mask, top level.
// ----------------------------------------------------------------------------
module compare_timer_bank_with_irq
  import ctb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      req_valid_r, req_valid_nxt;
  in_item_t  req_r;
  logic      adv;
  logic      fire;
  logic      take;
  out_item_t bank_res;

  assign adv      = !out_valid || !out_stall;
  assign fire     = req_valid_r && adv;
  assign in_stall = req_valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    if (take) begin
      req_valid_nxt = 1'b1;
    end else if (fire) begin
      req_valid_nxt = 1'b0;
    end else begin
      req_valid_nxt = req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_item;
    end
  end

  ctb_bank u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (req_r),
    .result (bank_res)
  );

  ctb_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_item (bank_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the compare timer bank with interrupt mask.
// Requests are queued by a stimulus process and offered by a clocked driver.
// Every accepted request runs through a local model of the five timers, and
// the monitor checks each result against the oldest predicted one. A short
// directed run covers the corner cases, then random register traffic and
// ticks run under several sender and receiver idling patterns. The last
// phase holds the result side off so that the bank backs up.
// ----------------------------------------------------------------------------
module testbench;
  import ctb_pkg::*;

  typedef enum int {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_PRESSURE
  } phase_t;

  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(NUM_TIMERS - 1);
  localparam logic [1:0]       KIND_UNUSED = 2'd3;
  localparam int               HOLD_CYCLES = 64;
  localparam int               IDLE_LIMIT  = 4000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  in_item_t  timer_req_q[$];
  out_item_t expected_out_q[$];
  phase_t    phase = PH_STEADY;
  int        err_count = 0;
  int        idle_cycles = 0;
  int        hold_len = 0;
  bit        hold_done = 1'b0;

  // local copy of the timer state
  logic [DATA_W-1:0] tmr_count  [NUM_TIMERS] = '{default: '0};
  logic [DATA_W-1:0] tmr_target [NUM_TIMERS] = '{default: '0};
  logic              tmr_en     [NUM_TIMERS] = '{default: 1'b0};
  logic              tmr_restart[NUM_TIMERS] = '{default: 1'b0};
  logic              tmr_status [NUM_TIMERS] = '{default: 1'b0};

  compare_timer_bank_with_irq dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic bit roll_pct(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic out_item_t timer_bank_apply(in_item_t req);
    out_item_t res;
    int        t;
    logic [DATA_W-1:0] v;
    res = '0;
    v   = '0;
    t   = int'(req.timer_index);
    case (req.kind)
      KIND_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (tmr_en[i]) begin
            tmr_count[i] = tmr_count[i] + DATA_W'(req.tick_cycles);
            if (tmr_count[i] >= tmr_target[i]) begin
              tmr_status[i] = 1'b1;
              if (i < IRQ_W) res.irq_mask[i] = 1'b1;
            end
          end
        end
      end
      KIND_READ: begin
        if (t < NUM_TIMERS) begin
          case (req.reg_select)
            REG_TARGET: v = (req.timer_index == LAST_IDX) ?
                            tmr_target[t] << LAST_SHIFT : tmr_target[t];
            REG_COUNT:  v = (req.timer_index == LAST_IDX) ?
                            tmr_count[t] << LAST_SHIFT : tmr_count[t];
            REG_CTRL: begin
              v[CTRL_RESTART_BIT] = tmr_restart[t];
              v[CTRL_ENABLE_BIT]  = tmr_en[t];
            end
            default: v[STATUS_BIT] = tmr_status[t];
          endcase
        end
        res.read_data = v;
      end
      KIND_WRITE: begin
        if (t < NUM_TIMERS) begin
          case (req.reg_select)
            REG_TARGET: tmr_target[t] = (req.timer_index == LAST_IDX) ?
                                        req.write_data >> LAST_SHIFT : req.write_data;
            REG_CTRL: begin
              if (req.write_data[CTRL_CLR_BIT]) tmr_count[t] = '0;
              tmr_restart[t] = req.write_data[CTRL_RESTART_BIT];
              tmr_en[t]      = req.write_data[CTRL_ENABLE_BIT];
            end
            REG_STATUS: tmr_status[t] = tmr_status[t] & req.write_data[STATUS_BIT];
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t mk_req(logic [1:0] kind, logic [1:0] sel,
                                      logic [IDX_W-1:0] idx,
                                      logic [DATA_W-1:0] data,
                                      logic [CYC_W-1:0] cyc);
    in_item_t r;
    r.kind        = kind;
    r.reg_select  = sel;
    r.timer_index = idx;
    r.write_data  = data;
    r.tick_cycles = cyc;
    return r;
  endfunction

  // mostly sensible traffic: small targets and enabled timers so matches occur
  function automatic in_item_t rand_req();
    in_item_t r;
    int       roll;
    roll          = $urandom_range(99);
    r.write_data  = $urandom();
    r.tick_cycles = CYC_W'($urandom());
    r.reg_select  = 2'($urandom());
    r.timer_index = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(7, NUM_TIMERS)) :
                                               IDX_W'($urandom_range(NUM_TIMERS - 1));
    if (roll < 38) begin
      r.kind = KIND_TICK;
      if ($urandom_range(3) == 0) r.tick_cycles = CYC_W'($urandom_range(255));
    end else if (roll < 66) begin
      r.kind = KIND_READ;
    end else if (roll < 95) begin
      r.kind = KIND_WRITE;
      if (r.reg_select == REG_TARGET && $urandom_range(3) != 0)
        r.write_data = DATA_W'($urandom_range(400000));
      if (r.reg_select == REG_CTRL)
        r.write_data[CTRL_ENABLE_BIT] = ($urandom_range(4) != 0);
    end else begin
      r.kind = KIND_UNUSED;
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (timer_req_q.size() != 0 || in_valid || expected_out_q.size() != 0)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic held;
    int   pct;
    held = in_valid && in_stall;
    pct  = (phase == PH_SEND_IDLE) ? 79 : (phase == PH_BOTH) ? 24 : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_out_q.push_back(timer_bank_apply(in_item));
      if (!held) begin
        if (timer_req_q.size() != 0 && !roll_pct(pct)) begin
          in_valid <= 1'b1;
          in_item  <= timer_req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off in the pressure phase
  always @(posedge clk) begin : receive
    int pct;
    pct = (phase == PH_RECV_STALL) ? 79 : (phase == PH_BOTH) ? 24 : 0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (phase == PH_PRESSURE && !hold_done) begin
      if (hold_len < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        hold_len++;
      end else begin
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end
    end else begin
      out_stall <= roll_pct(pct);
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_out_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", out_item));
      end else begin
        want = expected_out_q.pop_front();
        if (out_item.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h, expected %h",
                                    out_item.read_data, want.read_data));
        if (out_item.irq_mask !== want.irq_mask)
          report_mismatch($sformatf("irq_mask %b, expected %b",
                                    out_item.irq_mask, want.irq_mask));
      end
    end
  end

  // watchdog on cycles without any request or result moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    phase_t plan[5];
    int     plan_len[5];
    plan     = '{PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE};
    plan_len = '{180, 170, 170, 170, 60};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    timer_req_q.push_back(mk_req(KIND_READ,  REG_TARGET, IDX_W'(0), '0, '0));
    timer_req_q.push_back(mk_req(KIND_WRITE, REG_TARGET, IDX_W'(0), 32'd100, '1));
    timer_req_q.push_back(mk_req(KIND_WRITE, REG_TARGET, LAST_IDX, '1, '0));
    timer_req_q.push_back(mk_req(KIND_READ,  REG_TARGET, LAST_IDX, '0, '0));
    timer_req_q.push_back(mk_req(KIND_WRITE, REG_CTRL,   IDX_W'(0), 32'h7, '0));
    timer_req_q.push_back(mk_req(KIND_READ,  REG_CTRL,   IDX_W'(0), '1, '1));
    timer_req_q.push_back(mk_req(KIND_TICK,  REG_TARGET, IDX_W'(0), '0, '0));
    // count lands exactly on the target
    timer_req_q.push_back(mk_req(KIND_TICK,  REG_TARGET, IDX_W'(0), '0, 16'd100));
    timer_req_q.push_back(mk_req(KIND_TICK,  REG_TARGET, IDX_W'(0), '0, '1));
    timer_req_q.push_back(mk_req(KIND_READ,  REG_STATUS, IDX_W'(0), '0, '0));
    // count is not writable
    timer_req_q.push_back(mk_req(KIND_WRITE, REG_COUNT,  IDX_W'(0), 32'hDEAD_BEEF, '0));
    timer_req_q.push_back(mk_req(KIND_READ,  REG_COUNT,  IDX_W'(0), '0, '0));
    timer_req_q.push_back(mk_req(KIND_WRITE, REG_STATUS, IDX_W'(0), 32'h1, '0));
    timer_req_q.push_back(mk_req(KIND_WRITE, REG_STATUS, IDX_W'(0), 32'hFFFF_FFFE, '0));
    timer_req_q.push_back(mk_req(KIND_READ,  REG_STATUS, IDX_W'(0), '0, '0));
    timer_req_q.push_back(mk_req(KIND_WRITE, REG_CTRL,   LAST_IDX, 32'h4, '0));
    timer_req_q.push_back(mk_req(KIND_TICK,  REG_CTRL,   LAST_IDX, '0, '1));
    timer_req_q.push_back(mk_req(KIND_READ,  REG_COUNT,  LAST_IDX, '0, '0));
    // out-of-range timer index
    timer_req_q.push_back(mk_req(KIND_WRITE, REG_TARGET, IDX_W'(7), 32'h1, '0));
    timer_req_q.push_back(mk_req(KIND_READ,  REG_TARGET, IDX_W'(7), '0, '0));
    timer_req_q.push_back(mk_req(KIND_WRITE, REG_CTRL,   IDX_W'(5), 32'h4, '0));
    // unused kind
    timer_req_q.push_back(mk_req(KIND_UNUSED, REG_CTRL,  IDX_W'(1), '1, '1));
    for (int i = 1; i < NUM_TIMERS - 1; i++)
      timer_req_q.push_back(mk_req(KIND_WRITE, REG_CTRL, IDX_W'(i), 32'h5, '0));
    timer_req_q.push_back(mk_req(KIND_WRITE, REG_TARGET, LAST_IDX, '0, '0));
    timer_req_q.push_back(mk_req(KIND_TICK,  REG_TARGET, IDX_W'(0), '0, 16'd1));
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      phase = plan[p];
      repeat (plan_len[p]) timer_req_q.push_back(rand_req());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/ctb_pkg.sv
src/ctb_bank.sv
src/ctb_out_reg.sv
src/compare_timer_bank_with_irq.sv
tb/sv/testbench.sv
